@@ sv/avpts_pkg.sv @@
// Package for the presentation timestamp generator.
// Holds sizes, timing constants, status and register codes, and the
// command and status structs between controller and datapath.
`default_nettype none

package avpts_pkg;

    // Sizes
    localparam int STREAM_SLOTS   = 4;
    localparam int SLOT_BITS      = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;
    localparam int STAMP_BITS     = 48;
    localparam int SEL_BITS       = 4;
    localparam int CODEC_BITS     = 4;
    localparam int CODEC_SLOTS    = 4;
    localparam int RATE_BITS      = 18;
    localparam int CLOCK_BITS     = 48;
    localparam int STATUS_BITS    = 3;
    localparam int ACTIVE_BITS    = 3;
    localparam int SYNC_SEL_BITS  = 3;
    localparam int MASK_BITS      = 4;
    localparam int MAP_BITS       = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // Timing constants, in 90 kHz ticks except the AAC frame size in samples
    localparam int TICKS_PER_SEC     = 90000;
    localparam int AAC_FRAME_SAMPLES = 1024;
    localparam int START_STAMP       = 90000;
    localparam int MS1_TICKS         = 90;
    localparam int WIN_QUARTER       = 22500;
    localparam int WIN_HALF          = 45000;

    // Divider operand: the audio numerator is the widest dividend
    localparam longint DIV_AUDIO   = longint'(TICKS_PER_SEC) * AAC_FRAME_SAMPLES;
    localparam int DIVIDEND_BITS   = $clog2(DIV_AUDIO + 1);

    // Reset values of the configuration registers
    localparam int RST_ACTIVE     = 1;
    localparam int RST_VIDEO_MASK = 1;
    localparam int RST_CODEC_MAP  = 0;
    localparam int RST_AUDIO_SYNC = 4;
    localparam int RST_AAC        = 1;
    localparam int RST_AAC_ADTS   = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK          = 3'd0,
        ST_DROPPED     = 3'd1,
        ST_BAD_INDEX   = 3'd2,
        ST_CODEC_MISMATCH = 3'd3,
        ST_UNSUPPORTED = 3'd4,
        ST_ZERO_RATE   = 3'd5
    } status_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ACTIVE_STREAMS = 3'd0,
        CFG_VIDEO_MASK     = 3'd1,
        CFG_CODEC_MAP      = 3'd2,
        CFG_AUDIO_SYNC     = 3'd3,
        CFG_AAC_CODE       = 3'd4,
        CFG_AAC_ADTS_CODE  = 3'd5
    } cfg_idx_t;

    // Outcome of the checks on one frame
    typedef enum logic [1:0] {
        KIND_ERR   = 2'd0,
        KIND_FIRST = 2'd1,
        KIND_STEP  = 2'd2
    } kind_t;

    typedef struct packed {
        logic take;       // latch the accepted input word
        logic eval;       // run checks, latch start, read stamp memory
        logic first;      // form first stamp of a stream
        logic div_start;  // launch the rate division
        logic step;       // form step candidates
        logic sync;       // pick the final stamp
        logic load_out;   // load the output word and commit state
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  div_done;
    } stat_t;

endpackage

`default_nettype wire

@@ sv/avpts_if.sv @@
// Channel interfaces for the timestamp generator: input frame word,
// output result word and configuration write. Depends on avpts_pkg.
`default_nettype none

interface avpts_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [avpts_pkg::SEL_BITS-1:0]        stream_sel;
    logic [avpts_pkg::CODEC_BITS-1:0]      codec_code;
    logic [avpts_pkg::RATE_BITS-1:0]       rate;
    logic                                  key_frame;
    logic [avpts_pkg::CLOCK_BITS-1:0]      clock_ticks;
    logic                                  wall_valid;

    modport source (output valid, stream_sel, codec_code, rate, key_frame, clock_ticks,
                    wall_valid, input ready);
    modport sink (input valid, stream_sel, codec_code, rate, key_frame, clock_ticks,
                  wall_valid, output ready);
endinterface

interface avpts_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [avpts_pkg::STATUS_BITS-1:0]     status;
    logic [avpts_pkg::STAMP_BITS-1:0]      pts;

    modport source (output valid, status, pts, input ready);
    modport sink (input valid, status, pts, output ready);
endinterface

interface avpts_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [avpts_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [avpts_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ sv/avpts_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on avpts_pkg for operand widths.
`default_nettype none

module avpts_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [avpts_pkg::DIVIDEND_BITS-1:0]   dividend,
    input  wire logic [avpts_pkg::RATE_BITS-1:0]       divisor,
    output logic                                       done,
    output logic [avpts_pkg::DIVIDEND_BITS-1:0]        quotient
);

    localparam int CNT_BITS = $clog2(avpts_pkg::DIVIDEND_BITS);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [CNT_BITS-1:0]                   cnt_reg;
    logic [avpts_pkg::RATE_BITS-1:0]       rem_reg;
    logic [avpts_pkg::RATE_BITS-1:0]       dsr_reg;
    logic [avpts_pkg::DIVIDEND_BITS-1:0]   quo_reg;
    logic [avpts_pkg::RATE_BITS:0]         trial;
    logic                                  fits;

    assign trial = {rem_reg, quo_reg[avpts_pkg::DIVIDEND_BITS-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(avpts_pkg::DIVIDEND_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift a dividend bit into the remainder, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dsr_reg <= divisor;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= avpts_pkg::RATE_BITS'(trial - {1'b0, dsr_reg});
            else
                rem_reg <= trial[avpts_pkg::RATE_BITS-1:0];
            quo_reg <= {quo_reg[avpts_pkg::DIVIDEND_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still iterating");

endmodule

`default_nettype wire

@@ sv/avpts_dp.sv @@
// Datapath of the timestamp generator: configuration registers, input
// capture, stream state, stamp memory, divider and output register.
// Depends on avpts_pkg and avpts_div.
`default_nettype none

module avpts_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire avpts_pkg::cmd_t                       cmd,
    output avpts_pkg::stat_t                           stat,
    input  wire logic                                  cfg_we,
    input  wire logic [avpts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [avpts_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic [avpts_pkg::SEL_BITS-1:0]        in_stream_sel,
    input  wire logic [avpts_pkg::CODEC_BITS-1:0]      in_codec_code,
    input  wire logic [avpts_pkg::RATE_BITS-1:0]       in_rate,
    input  wire logic                                  in_key_frame,
    input  wire logic [avpts_pkg::CLOCK_BITS-1:0]      in_clock_ticks,
    input  wire logic                                  in_wall_valid,
    output logic [avpts_pkg::STATUS_BITS-1:0]          out_status,
    output logic [avpts_pkg::STAMP_BITS-1:0]           out_pts
);

    localparam int SB = avpts_pkg::STAMP_BITS;
    localparam int LB = avpts_pkg::SLOT_BITS;

    // Configuration
    logic [avpts_pkg::ACTIVE_BITS-1:0]    active_reg;
    logic [avpts_pkg::MASK_BITS-1:0]      video_mask_reg;
    logic [avpts_pkg::MAP_BITS-1:0]       codec_map_reg;
    logic [avpts_pkg::SYNC_SEL_BITS-1:0]  audio_sync_reg;
    logic [avpts_pkg::CODEC_BITS-1:0]     aac_reg;
    logic [avpts_pkg::CODEC_BITS-1:0]     aac_adts_reg;

    // Captured input word
    logic [avpts_pkg::SEL_BITS-1:0]       sel_reg;
    logic [avpts_pkg::CODEC_BITS-1:0]     codec_reg;
    logic [avpts_pkg::RATE_BITS-1:0]      rate_reg;
    logic                                 key_reg;
    logic [avpts_pkg::CLOCK_BITS-1:0]     clk_ticks_reg;
    logic                                 wall_reg;

    // Stream state
    logic                                 started_reg;
    logic [avpts_pkg::CLOCK_BITS-1:0]     start_time_reg;
    logic [avpts_pkg::STREAM_SLOTS-1:0]   stamp_valid_reg;
    logic [SB-1:0]                        stamp_mem [avpts_pkg::STREAM_SLOTS];

    // Per-frame work registers
    avpts_pkg::status_t                   status_reg;
    logic [avpts_pkg::CLOCK_BITS-1:0]     elapsed_reg;
    logic                                 use_sync_reg;
    logic [SB-1:0]                        last_rd_reg;
    logic [SB-1:0]                        sync_rd_reg;
    logic [SB-1:0]                        cand0_reg;
    logic [SB-1:0]                        cand1_reg;
    logic [SB-1:0]                        cand3_reg;
    logic [SB-1:0]                        pts_reg;
    logic [avpts_pkg::STATUS_BITS-1:0]    out_status_reg;
    logic [SB-1:0]                        out_pts_reg;

    // Check logic
    logic [LB-1:0]                        slot;
    logic [LB-1:0]                        sync_slot;
    logic                                 bad_index;
    logic [avpts_pkg::CODEC_BITS-1:0]     stream_codec;
    logic                                 is_video;
    logic                                 is_aac;
    logic                                 start_now;
    logic                                 started_eff;
    logic                                 sync_ok;
    avpts_pkg::kind_t                     kind;
    avpts_pkg::status_t                   status_next;
    logic [avpts_pkg::CLOCK_BITS-1:0]     elapsed_next;
    logic [avpts_pkg::DIVIDEND_BITS-1:0]  dividend;
    logic [avpts_pkg::DIVIDEND_BITS-1:0]  quotient;
    logic                                 div_done;
    logic [SB-1:0]                        ahead;
    logic [SB-1:0]                        behind;
    logic [SB-1:0]                        pts_sync;
    logic                                 commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= avpts_pkg::ACTIVE_BITS'(avpts_pkg::RST_ACTIVE);
            video_mask_reg <= avpts_pkg::MASK_BITS'(avpts_pkg::RST_VIDEO_MASK);
            codec_map_reg  <= avpts_pkg::MAP_BITS'(avpts_pkg::RST_CODEC_MAP);
            audio_sync_reg <= avpts_pkg::SYNC_SEL_BITS'(avpts_pkg::RST_AUDIO_SYNC);
            aac_reg        <= avpts_pkg::CODEC_BITS'(avpts_pkg::RST_AAC);
            aac_adts_reg   <= avpts_pkg::CODEC_BITS'(avpts_pkg::RST_AAC_ADTS);
        end
        else if (cfg_we)
        begin
            unique case (avpts_pkg::cfg_idx_t'(cfg_index))
                avpts_pkg::CFG_ACTIVE_STREAMS:
                    active_reg <= cfg_data[avpts_pkg::ACTIVE_BITS-1:0];
                avpts_pkg::CFG_VIDEO_MASK:
                    video_mask_reg <= cfg_data[avpts_pkg::MASK_BITS-1:0];
                avpts_pkg::CFG_CODEC_MAP:
                    codec_map_reg <= cfg_data[avpts_pkg::MAP_BITS-1:0];
                avpts_pkg::CFG_AUDIO_SYNC:
                    audio_sync_reg <= cfg_data[avpts_pkg::SYNC_SEL_BITS-1:0];
                avpts_pkg::CFG_AAC_CODE:
                    aac_reg <= cfg_data[avpts_pkg::CODEC_BITS-1:0];
                avpts_pkg::CFG_AAC_ADTS_CODE:
                    aac_adts_reg <= cfg_data[avpts_pkg::CODEC_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            sel_reg       <= in_stream_sel;
            codec_reg     <= in_codec_code;
            rate_reg      <= in_rate;
            key_reg       <= in_key_frame;
            clk_ticks_reg <= in_clock_ticks;
            wall_reg      <= in_wall_valid;
        end
    end

    // Checks, in order: index, codec, start, then stamp kind
    assign slot      = sel_reg[LB-1:0];
    assign sync_slot = audio_sync_reg[LB-1:0];
    assign bad_index = ({1'b0, sel_reg} >= {2'b00, active_reg})
                    || ({1'b0, sel_reg} >= 5'(avpts_pkg::STREAM_SLOTS));
    assign stream_codec = ({1'b0, sel_reg} < 5'(avpts_pkg::CODEC_SLOTS))
                        ? codec_map_reg[{sel_reg[1:0], 2'b00} +: avpts_pkg::CODEC_BITS]
                        : '0;
    assign is_video = ({1'b0, sel_reg} < 5'(avpts_pkg::MASK_BITS))
                   && video_mask_reg[sel_reg[1:0]];
    assign is_aac      = (stream_codec == aac_reg) || (stream_codec == aac_adts_reg);
    assign start_now   = !started_reg && is_video && key_reg && wall_reg;
    assign started_eff = started_reg || start_now;
    assign sync_ok     = ({2'b00, audio_sync_reg} < 5'(avpts_pkg::STREAM_SLOTS))
                      && stamp_valid_reg[sync_slot];
    assign elapsed_next = clk_ticks_reg - (start_now ? clk_ticks_reg : start_time_reg);
    assign dividend = is_video
                    ? avpts_pkg::DIVIDEND_BITS'(avpts_pkg::TICKS_PER_SEC)
                    : avpts_pkg::DIVIDEND_BITS'(avpts_pkg::DIV_AUDIO);

    always_comb
    begin
        kind        = avpts_pkg::KIND_ERR;
        status_next = avpts_pkg::ST_OK;
        if (bad_index)
            status_next = avpts_pkg::ST_BAD_INDEX;
        else if (stream_codec != codec_reg)
            status_next = avpts_pkg::ST_CODEC_MISMATCH;
        else if (!started_eff)
            status_next = avpts_pkg::ST_DROPPED;
        else if (!stamp_valid_reg[slot])
            kind = avpts_pkg::KIND_FIRST;
        else if (!is_video && !is_aac)
            status_next = avpts_pkg::ST_UNSUPPORTED;
        else if (rate_reg == '0)
            status_next = avpts_pkg::ST_ZERO_RATE;
        else
            kind = avpts_pkg::KIND_STEP;
    end

    // Latch the start even if a later check fails
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            start_time_reg  <= '0;
            stamp_valid_reg <= '0;
        end
        else
        begin
            if (cmd.eval && !bad_index && (stream_codec == codec_reg) && start_now)
            begin
                started_reg    <= 1'b1;
                start_time_reg <= clk_ticks_reg;
            end
            if (commit)
                stamp_valid_reg[slot] <= 1'b1;
        end
    end

    assign commit = cmd.load_out && (status_reg == avpts_pkg::ST_OK);

    always_ff @(posedge clk)
    begin
        if (commit)
            stamp_mem[slot] <= pts_reg;
        if (cmd.eval)
        begin
            last_rd_reg <= stamp_mem[slot];
            sync_rd_reg <= stamp_mem[sync_slot];
        end
    end

    avpts_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (rate_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Pull the video stamp toward the sync audio stamp
    assign ahead  = sync_rd_reg - cand0_reg;
    assign behind = cand0_reg - sync_rd_reg;

    always_comb
    begin
        pts_sync = cand0_reg;
        if (use_sync_reg)
        begin
            if (!ahead[SB-1])
            begin
                if (ahead > SB'(avpts_pkg::WIN_QUARTER))
                    pts_sync = sync_rd_reg;
            end
            else if (behind > SB'(avpts_pkg::WIN_HALF))
                pts_sync = cand3_reg;
            else if (behind > SB'(avpts_pkg::WIN_QUARTER))
                pts_sync = cand1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= avpts_pkg::ST_OK;
            out_status_reg <= avpts_pkg::ST_OK;
            out_pts_reg    <= '0;
        end
        else
        begin
            if (cmd.eval)
                status_reg <= status_next;
            if (cmd.load_out)
            begin
                out_status_reg <= status_reg;
                out_pts_reg    <= (status_reg == avpts_pkg::ST_OK) ? pts_reg : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            elapsed_reg  <= elapsed_next;
            use_sync_reg <= is_video && sync_ok;
        end
        if (cmd.step)
        begin
            cand0_reg <= last_rd_reg + SB'(quotient);
            cand1_reg <= last_rd_reg + SB'(quotient >> 1);
            cand3_reg <= last_rd_reg + SB'(quotient >> 3);
        end
        if (cmd.first)
        begin
            if (elapsed_reg <= avpts_pkg::CLOCK_BITS'(avpts_pkg::MS1_TICKS))
                pts_reg <= SB'(avpts_pkg::START_STAMP);
            else
                pts_reg <= SB'(elapsed_reg + avpts_pkg::CLOCK_BITS'(avpts_pkg::START_STAMP));
        end
        else if (cmd.sync)
            pts_reg <= pts_sync;
    end

    assign stat.kind     = kind;
    assign stat.div_done = div_done;
    assign out_status    = out_status_reg;
    assign out_pts       = out_pts_reg;

    a_commit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> stamp_valid_reg[$past(slot)])
        else $error("committed stamp not marked valid");

    a_err_pts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_status_reg != avpts_pkg::ST_OK) |-> (out_pts_reg == '0))
        else $error("non-zero pts on a rejected frame");

endmodule

`default_nettype wire

@@ sv/avpts_ctrl.sv @@
// Controller of the timestamp generator: one-hot sequencer that steps
// the datapath through check, first stamp or divide, step, select and output. Uses avpts_pkg.
`default_nettype none

module avpts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output avpts_pkg::cmd_t          cmd,
    input  wire avpts_pkg::stat_t    stat
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_FIRST = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_SYNC  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                unique case (stat.kind)
                    avpts_pkg::KIND_FIRST:
                        state_next = S_FIRST;
                    avpts_pkg::KIND_STEP:
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_FIRST:
            begin
                cmd.first  = 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SYNC;
            end
            S_SYNC:
            begin
                cmd.sync   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    a_take_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_EVAL))
        else $error("accepted word not evaluated next cycle");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("output register overwritten while held");

    a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && stat.div_done) |=> (state_reg == S_STEP))
        else $error("quotient not consumed");

endmodule

`default_nettype wire

@@ sv/av_pts_generator_with_sync_core.sv @@
// Top level of the presentation timestamp generator with audio sync.
// Joins avpts_ctrl and avpts_dp; uses avpts_pkg and the avpts_if channels.
`default_nettype none
//
//  channel  | dir | words carried                                    | handshake
//  ---------+-----+--------------------------------------------------+-----------
//  in_ch    | in  | stream_sel, codec_code, rate, key_frame,         | valid/ready
//           |     | clock_ticks, wall_valid                          |
//  out_ch   | out | status, pts                                      | valid/ready
//  cfg_ch   | in  | index, data (register write)                     | valid/ready
//
//  A word is taken and checked, then either finished at once (rejected
//  word, or first stamp of a stream) or sent through the shared restoring
//  divider, one quotient bit per cycle over 27 bits, then stepped and selected.
//  Reset loads the configuration defaults and clears start, stamp valid bits, the output register and the sequencer.
//  The output register holds a result until taken; the next input word
//  is accepted while it waits. cfg_ch is always ready.

module av_pts_generator_with_sync_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    avpts_in_if.sink         in_ch,
    avpts_out_if.source      out_ch,
    avpts_cfg_if.sink        cfg_ch
);

    avpts_pkg::cmd_t  cmd;
    avpts_pkg::stat_t stat;

    // Configuration writes go straight into their registers: never stall them
    assign cfg_ch.ready = 1'b1;

    // Sequencer: hold each word until its result is loaded out
    avpts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Checks, stream state, divider and output register
    avpts_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_ch.valid),
        .cfg_index      (cfg_ch.index),
        .cfg_data       (cfg_ch.data),
        .in_stream_sel  (in_ch.stream_sel),
        .in_codec_code  (in_ch.codec_code),
        .in_rate        (in_ch.rate),
        .in_key_frame   (in_ch.key_frame),
        .in_clock_ticks (in_ch.clock_ticks),
        .in_wall_valid  (in_ch.wall_valid),
        .out_status     (out_ch.status),
        .out_pts        (out_ch.pts)
    );

endmodule

`default_nettype wire
